### rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted priority queue
package spq_pkg;

	localparam int PRIO_REQ_W = 16;
	localparam int WORD_PART_W = 64;
	localparam int WORD_TAIL_W = 8;
	localparam int OCC_W = 5;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [WORD_PART_W-1:0] head;
		logic [WORD_PART_W-1:0] middle;
		logic [WORD_TAIL_W-1:0] tail;
	} word_t;

	typedef struct packed {
		func_t                  func;
		logic [PRIO_REQ_W-1:0]  priority_req;
		logic [WORD_PART_W-1:0] word_head;
		logic [WORD_PART_W-1:0] word_middle;
		logic [WORD_TAIL_W-1:0] word_tail;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [PRIO_REQ_W-1:0]  out_priority;
		logic [WORD_PART_W-1:0] out_word_head;
		logic [WORD_PART_W-1:0] out_word_middle;
		logic [WORD_TAIL_W-1:0] out_word_tail;
		logic [OCC_W-1:0]       occupancy;
	} rsp_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

### rtl/core/spq_req_if.sv
`timescale 1ns / 1ps
// request channel interface
interface spq_req_if;
	spq_pkg::req_t data;
	logic          valid;
	logic          ready;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/spq_rsp_if.sv
`timescale 1ns / 1ps
// response channel interface
interface spq_rsp_if;
	spq_pkg::rsp_t data;
	logic          valid;
	logic          ready;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/spq_cell.sv
`timescale 1ns / 1ps
// one slot of the shift-register queue with its local compare
module spq_cell #(
	parameter int PRIO_BITS = 16
) (
	input  logic                 clk,
	input  spq_pkg::cell_ctrl_t  ctrl,
	input  logic                 occupied,
	input  logic [PRIO_BITS-1:0] new_prio,
	input  spq_pkg::word_t       new_word,
	input  logic                 left_take,
	input  logic [PRIO_BITS-1:0] left_prio,
	input  spq_pkg::word_t       left_word,
	input  logic [PRIO_BITS-1:0] right_prio,
	input  spq_pkg::word_t       right_word,
	output logic                 take,
	output logic [PRIO_BITS-1:0] prio,
	output spq_pkg::word_t       word
);
	import spq_pkg::*;

	logic [PRIO_BITS-1:0] prio_q;
	word_t                word_q;

	// new entry goes ahead of this slot if empty or not strictly lower
	assign take = occupied ? (new_prio >= prio_q) : 1'b1;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_take) begin
				prio_q <= left_prio;
				word_q <= left_word;
			end else if (take) begin
				prio_q <= new_prio;
				word_q <= new_word;
			end
		end else if (ctrl.rem) begin
			prio_q <= right_prio;
			word_q <= right_word;
		end
	end

	assign prio = prio_q;
	assign word = word_q;

endmodule

### rtl/core/sorted_priority_queue.sv
`timescale 1ns / 1ps
// sorted priority queue top level: cell chain, fill count and response register
//
//  channel  dir  payload                                             handshake
//  req      in   func, priority_req, word_head/middle/tail           valid/ready
//  rsp      out  status, out_priority, out_word_*, occupancy         valid/ready
//
// one transaction per cycle while req.ready is high: every cell compares the broadcast
//   priority in the same cycle and shifts left or right when the request is accepted
// the response is registered and appears the cycle after the request is accepted
// reset clears the fill count and the response valid; slot contents stay undefined
// req.ready is high while the response register is empty or being taken
module sorted_priority_queue #(
	parameter int DEPTH     = 16,
	parameter int PRIO_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	// fill count and response register
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;

	logic       accept;
	logic       is_ins;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;

	// incoming entry, priority trimmed to the stored width
	logic [31:0]          pr_wide;
	logic [PRIO_BITS-1:0] new_prio;
	word_t                new_word;

	// cell chain outputs
	logic [PRIO_BITS-1:0] cell_prio [DEPTH];
	word_t                cell_word [DEPTH];
	logic                 cell_take [DEPTH];

	logic [31:0]   head_wide;
	logic [CW+4:0] occ_wide;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_ins    = (req.data.func == FUNC_INSERT);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	assign ctrl.ins = accept && is_ins && !full;
	assign ctrl.rem = accept && !is_ins && !empty;

	assign pr_wide         = {16'b0, req.data.priority_req};
	assign new_prio        = pr_wide[PRIO_BITS-1:0];
	assign new_word.head   = req.data.word_head;
	assign new_word.middle = req.data.word_middle;
	assign new_word.tail   = req.data.word_tail;

	// the chain: slot 0 is the head, inserts push right, removes pull left
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 left_take;
		logic [PRIO_BITS-1:0] left_prio;
		word_t                left_word;
		logic [PRIO_BITS-1:0] right_prio;
		word_t                right_word;

		if (i == 0) begin : g_first
			assign left_take = 1'b0;
			assign left_prio = new_prio;
			assign left_word = new_word;
		end else begin : g_mid
			assign left_take = cell_take[i-1];
			assign left_prio = cell_prio[i-1];
			assign left_word = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			// last slot keeps its old contents on remove, it is beyond the count then
			assign right_prio = cell_prio[i];
			assign right_word = cell_word[i];
		end else begin : g_inner
			assign right_prio = cell_prio[i+1];
			assign right_word = cell_word[i+1];
		end

		spq_cell #(
			.PRIO_BITS(PRIO_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (count_q > CW'(i)),
			.new_prio  (new_prio),
			.new_word  (new_word),
			.left_take (left_take),
			.left_prio (left_prio),
			.left_word (left_word),
			.right_prio(right_prio),
			.right_word(right_word),
			.take      (cell_take[i]),
			.prio      (cell_prio[i]),
			.word      (cell_word[i])
		);
	end

	// next count and the response for this transaction
	assign head_wide = 32'(cell_prio[0]);
	assign occ_wide  = (CW + 5)'(count_d);

	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.rem) begin
			count_d = count_q - CW'(1);
		end

		rsp_d                 = '0;
		rsp_d.status          = ST_OK;
		rsp_d.occupancy       = occ_wide[4:0];
		if (is_ins) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.out_priority    = head_wide[15:0];
			rsp_d.out_word_head   = cell_word[0].head;
			rsp_d.out_word_middle = cell_word[0].middle;
			rsp_d.out_word_tail   = cell_word[0].tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// count stays within the chain
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// a dropped insert leaves the count alone and reports full
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_ins && full) |=>
			(rsp.valid && rsp.data.status == ST_FULL && count_q == CW'(DEPTH)))
		else $error("insert into full queue not dropped");

	// a good remove lowers the count by one and hands out the old head
	a_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_ins && !empty) |=>
			(count_q == $past(count_q) - CW'(1) &&
			 rsp.data.out_word_head == $past(cell_word[0].head)))
		else $error("remove did not pop the head");

	// the two front slots stay in descending order
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]))
		else $error("head slots out of order");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted priority queue
module tb_top;
	import spq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int PRIO_BITS   = 16;
	// cycles during which neither side idles
	localparam int QUIET_START = 1200;
	localparam int QUIET_END   = 1800;
	// long receiver hold-off, started once enough requests have gone in
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_FIRST  = 1000;
	localparam int RAND_SECOND = 880;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue #(
		.DEPTH     (DEPTH),
		.PRIO_BITS (PRIO_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// requests waiting to be offered, filled by the stimulus block
	req_t        pending_reqs[$];
	// responses the queue must still return, oldest first
	rsp_t        expected_rsps[$];
	int unsigned mismatches;
	int unsigned reqs_taken;
	int unsigned cyc;

	// shadow copy of the sorted store, slot 0 is the head
	logic [PRIO_BITS-1:0] shadow_prio[DEPTH];
	word_t                shadow_word[DEPTH];
	int                   shadow_count;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) cyc <= cyc + 1;

	// random idling outside the quiet window, with a chance of about 12 percent per call
	function automatic bit idle_now();
		if (cyc >= QUIET_START && cyc < QUIET_END)
			return 1'b0;
		return $urandom_range(0, 99) < 12;
	endfunction

	// apply one operation to the shadow store and build the response it yields
	task automatic apply_queue_op(input req_t r, output rsp_t res);
		logic [PRIO_BITS-1:0] pr;
		int                   pos;
		pr = r.priority_req[PRIO_BITS-1:0];
		res = '0;
		res.status = ST_OK;
		if (r.func == FUNC_INSERT) begin
			if (shadow_count >= DEPTH) begin
				// full store: entry dropped, nothing changes
				res.status = ST_FULL;
			end else begin
				// skip strictly higher priorities, so equal ones land newest first
				pos = 0;
				while (pos < shadow_count && pr < shadow_prio[pos])
					pos++;
				for (int i = shadow_count; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_word[i] = shadow_word[i-1];
				end
				shadow_prio[pos] = pr;
				shadow_word[pos] = '{head: r.word_head, middle: r.word_middle,
					tail: r.word_tail};
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			// remove from empty store: zeros with an error status
			res.status = ST_EMPTY;
		end else begin
			res.out_priority    = PRIO_REQ_W'(shadow_prio[0]);
			res.out_word_head   = shadow_word[0].head;
			res.out_word_middle = shadow_word[0].middle;
			res.out_word_tail   = shadow_word[0].tail;
			for (int i = 1; i < shadow_count; i++) begin
				shadow_prio[i-1] = shadow_prio[i];
				shadow_word[i-1] = shadow_word[i];
			end
			shadow_count--;
		end
		res.occupancy = OCC_W'(shadow_count);
	endtask

	// request driver: a new transaction only when the last one was taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && !idle_now()) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= pending_reqs.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response ready: random stalls plus one long hold-off that backs the queue up
	int hold_left;
	bit hold_done;
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && reqs_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !idle_now();
			end
		end
	end

	// monitor: check responses first, then predict for the accepted request
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		rsp_t pred;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response: st=%0d pr=%h w=%h_%h_%h occ=%0d",
							got.status, got.out_priority, got.out_word_tail,
							got.out_word_middle, got.out_word_head, got.occupancy);
				end else begin
					want = expected_rsps.pop_front();
					if (got.status !== want.status
					    || got.out_priority !== want.out_priority
					    || got.out_word_head !== want.out_word_head
					    || got.out_word_middle !== want.out_word_middle
					    || got.out_word_tail !== want.out_word_tail
					    || got.occupancy !== want.occupancy) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("expected st=%0d pr=%h w=%h_%h_%h occ=%0d",
								want.status, want.out_priority, want.out_word_tail,
								want.out_word_middle, want.out_word_head, want.occupancy);
							$display("  actual st=%0d pr=%h w=%h_%h_%h occ=%0d",
								got.status, got.out_priority, got.out_word_tail,
								got.out_word_middle, got.out_word_head, got.occupancy);
						end
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				apply_queue_op(req_ch.data, pred);
				expected_rsps.push_back(pred);
				reqs_taken++;
			end
		end
	end

	// random 64-bit word part, with all-zero and all-one values now and then
	function automatic logic [63:0] rand_part();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// random operation; a narrow priority range makes equal priorities common
	function automatic req_t rand_op(int ins_pct);
		req_t r;
		r.func = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
		case ($urandom_range(0, 7))
			0: r.priority_req = '0;
			1: r.priority_req = '1;
			2, 3, 4: r.priority_req = PRIO_REQ_W'($urandom_range(0, 3));
			default: r.priority_req = PRIO_REQ_W'($urandom());
		endcase
		r.word_head   = rand_part();
		r.word_middle = rand_part();
		r.word_tail   = WORD_TAIL_W'($urandom());
		return r;
	endfunction

	function automatic req_t mk_op(func_t f, logic [15:0] pr, logic [63:0] h,
		logic [63:0] m, logic [7:0] t);
		req_t r;
		r.func         = f;
		r.priority_req = pr;
		r.word_head    = h;
		r.word_middle  = m;
		r.word_tail    = t;
		return r;
	endfunction

	// sender pause: nothing in flight and every expected response returned
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	// push a run of random operations in chunks with a varying insert mix
	task automatic push_random(int count);
		int ins_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 4))
					0: ins_pct = 25;
					1, 2: ins_pct = 50;
					3: ins_pct = 75;
					default: ins_pct = 90;
				endcase
			end
			pending_reqs.push_back(rand_op(ins_pct));
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		arst_n       = 1'b0;
		mismatches   = 0;
		reqs_taken   = 0;
		cyc          = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		shadow_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: remove from empty, priority and word extremes,
		// equal priorities (newest first), fill to the limit, insert into full
		pending_reqs.push_back(mk_op(FUNC_REMOVE, 16'hffff, '1, '1, 8'hff));
		pending_reqs.push_back(mk_op(FUNC_INSERT, 16'hffff, '1, '1, 8'hff));
		pending_reqs.push_back(mk_op(FUNC_INSERT, 16'h0000, '0, '0, 8'h00));
		pending_reqs.push_back(mk_op(FUNC_INSERT, 16'h8000, 64'h5555_5555_5555_5555,
			64'haaaa_aaaa_aaaa_aaaa, 8'h55));
		pending_reqs.push_back(mk_op(FUNC_INSERT, 16'h8000, 64'haaaa_aaaa_aaaa_aaaa,
			64'h5555_5555_5555_5555, 8'haa));
		for (int i = 0; i < 12; i++)
			pending_reqs.push_back(mk_op(FUNC_INSERT, 16'(i * 16'h1555), rand_part(),
				rand_part(), 8'($urandom())));
		pending_reqs.push_back(mk_op(FUNC_INSERT, 16'h7fff, '1, '0, 8'h80));
		repeat (5)
			pending_reqs.push_back(mk_op(FUNC_REMOVE, '0, '0, '0, 8'h00));
		wait_drained();

		// random part, split by a full pause of the sender
		push_random(RAND_FIRST);
		wait_drained();
		push_random(RAND_SECOND);
		wait_drained();

		// let the clock run on so any stray response shows up
		repeat (10) @(posedge clk);
		if (expected_rsps.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
rtl/core/spq_pkg.sv
rtl/core/spq_req_if.sv
rtl/core/spq_rsp_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/tb_top.sv
